@@ hw/rtl/mlp_pkg.sv @@
// Package for the feed-forward network block: sizes, register indexes, sigmoid table.
// Used by mlp_sigmoid, mlp_feedforward_sigmoid, mlp_ff_checker and tb; no dependencies.
`default_nettype none
package mlp_pkg;
    localparam int CFG_NUM_LAYERS = 0;
    localparam int CFG_LAYER0     = 1;
    localparam int CFG_LAYER1     = 2;
    localparam int CFG_LAYER2     = 3;
    localparam int CFG_LAYER3     = 4;

    localparam logic REQ_WEIGHT = 1'b0;
    localparam logic REQ_INPUT  = 1'b1;

    localparam int SIG_ENTRIES = 1024;

    // Sigmoid of i/64 in Q1.12, computed at elaboration by the fixed-point exp recurrence.
    typedef logic [12:0] sig_rom_t [SIG_ENTRIES];

    // Restoring long division, one quotient bit per step.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= 65'(den))
            begin
                rem = rem - 65'(den);
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic sig_rom_t build_sig_rom();
        sig_rom_t t;
        logic [63:0] e;
        logic [63:0] q;
        logic [127:0] m;
        e = 64'd1 << 32;
        for (int i = 0; i < SIG_ENTRIES; i++)
        begin
            q = (64'd1 << 32) + e;
            t[i] = 13'(udiv64((64'd1 << 44) + (q >> 1), q));
            m = 128'(e) * 128'd4228380000 + (128'd1 << 31);
            e = 64'(m >> 32);
        end
        return t;
    endfunction

    localparam sig_rom_t SIG_ROM = build_sig_rom();
endpackage
`default_nettype wire

@@ hw/rtl/mlp_sigmoid.sv @@
// Registered table sigmoid of a Q.12 sum with a selectable input shift.
// Depends on mlp_pkg for the table.
`default_nettype none
module mlp_sigmoid (
    input  wire logic               clk,
    input  wire logic signed [31:0] sum,
    input  wire logic               final_node,
    output logic [12:0]             act
);
    import mlp_pkg::*;

    localparam int IW = $clog2(SIG_ENTRIES);

    logic [32:0] mag;
    logic [32:0] idx_full;
    logic [IW-1:0] idx;
    logic [12:0] t;

    always_comb
    begin
        mag = sum[31] ? 33'(-34'(sum)) : 33'(sum);
        if (final_node)
            idx_full = (mag + 33'd256) >> 9;
        else
            idx_full = (mag + 33'd32) >> 6;
        if (idx_full >= 33'(SIG_ENTRIES - 1))
            idx = IW'(SIG_ENTRIES - 1);
        else
            idx = idx_full[IW-1:0];
        t = SIG_ROM[idx];
    end

    always_ff @(posedge clk)
    begin
        act <= sum[31] ? 13'(13'd4096 - t) : t;
    end
endmodule
`default_nettype wire

@@ hw/rtl/mlp_feedforward_sigmoid.sv @@
// Top level of the fixed-point feed-forward network with sigmoid activations.
// Depends on mlp_pkg and mlp_sigmoid.
`default_nettype none
// Usage:
//  Command channel: start with req_type/index/value/last is taken when busy is low.
//  A weight item (req_type 0) is written into the weight memory.
//  An input item (req_type 1) loads an input node; with last high it starts an
//  evaluation that ends in one score on done for one cycle.
//  One shared multiply-accumulate unit runs every weight; each MAC steps through
//  source node read, source capture, multiply with destination node read and
//  saturating accumulate, and each hidden node first passes through the sigmoid.
//  After each evaluation all MAX_LAYERS*MAX_LAYER_WIDTH node memory entries are
//  cleared, one entry a cycle, while busy stays high.
//  After reset the same clearing pass runs too.
//  The receiver cannot stall: done is a one-cycle strobe.
//  The user must write configuration over the APB port only while busy is low; the block does not enforce it.
module mlp_feedforward_sigmoid #(
    parameter int MAX_LAYERS          = 4,
    parameter int MAX_LAYER_WIDTH     = 64,
    parameter int WEIGHT_DEPTH        = 16384
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               req_type,
    input  wire logic [13:0]        index,
    input  wire logic signed [15:0] value,
    input  wire logic               last,
    output logic                    done,
    output logic [12:0]             score
);
    import mlp_pkg::*;

    localparam int SLOTS = MAX_LAYERS * MAX_LAYER_WIDTH;
    localparam int NW    = $clog2(SLOTS);
    localparam int WW    = $clog2(WEIGHT_DEPTH);
    localparam int JW    = $clog2(MAX_LAYER_WIDTH + 1);
    localparam int LW    = $clog2(MAX_LAYERS + 1);
    localparam int CW    = $clog2(MAX_LAYER_WIDTH);
    localparam int LIW   = (MAX_LAYERS > 2) ? $clog2(MAX_LAYERS) : 1;
    localparam int PW    = 22;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LAYER, S_ACT_RD, S_ACT_WAIT, S_ACT_WR,
        S_MAC_RD, S_MAC_RD2, S_MAC_MUL, S_MAC_ACC, S_FIN_RD, S_FIN_WAIT, S_FIN_OUT
    } state_t;

    // configuration
    logic [2:0] num_layers_reg;
    logic [6:0] lsize_reg [4];

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_layers_reg <= 3'd3;
            lsize_reg[0] <= 7'd64;
            lsize_reg[1] <= 7'd32;
            lsize_reg[2] <= 7'd1;
            lsize_reg[3] <= 7'd1;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[4:2])
                3'(CFG_NUM_LAYERS): num_layers_reg <= pwdata[2:0];
                3'(CFG_LAYER0):     lsize_reg[0] <= pwdata[6:0];
                3'(CFG_LAYER1):     lsize_reg[1] <= pwdata[6:0];
                3'(CFG_LAYER2):     lsize_reg[2] <= pwdata[6:0];
                3'(CFG_LAYER3):     lsize_reg[3] <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            3'(CFG_NUM_LAYERS): prdata = {29'd0, num_layers_reg};
            3'(CFG_LAYER0):     prdata = {25'd0, lsize_reg[0]};
            3'(CFG_LAYER1):     prdata = {25'd0, lsize_reg[1]};
            3'(CFG_LAYER2):     prdata = {25'd0, lsize_reg[2]};
            3'(CFG_LAYER3):     prdata = {25'd0, lsize_reg[3]};
            default:            prdata = 32'd0;
        endcase
    end

    // clamped sizes; layers beyond the four registers act as size 1
    function automatic logic [JW-1:0] clamp_size(input logic [6:0] v);
        if (v == 7'd0)
            return JW'(1);
        else if (32'(v) > MAX_LAYER_WIDTH)
            return JW'(MAX_LAYER_WIDTH);
        else
            return JW'(v);
    endfunction

    function automatic logic [JW-1:0] size_of(input logic [LW-1:0] l);
        logic [JW-1:0] r;
        r = JW'(1);
        for (int k = 0; k < 4; k++)
            if (32'(l) == k)
                r = clamp_size(lsize_reg[k]);
        return r;
    endfunction

    logic [LW-1:0] layers;
    always_comb
    begin
        if (num_layers_reg < 3'd2)
            layers = LW'(2);
        else if (32'(num_layers_reg) > MAX_LAYERS)
            layers = LW'(MAX_LAYERS);
        else
            layers = LW'(num_layers_reg);
    end

    // memories
    logic signed [15:0] wmem [WEIGHT_DEPTH];
    logic signed [31:0] nmem [SLOTS];
    logic signed [15:0] wrd;
    logic signed [31:0] nrd;

    state_t state_reg;
    logic [LW-1:0] lp_reg;
    logic [JW-1:0] s_reg, d_reg, ns_reg, nd_reg;
    logic [PW-1:0] wp_reg, woff_reg;
    logic [NW:0]   clr_reg;
    logic signed [31:0] src_reg;
    logic signed [47:0] prod_reg;
    logic [12:0] act;

    logic        w_we;
    logic [WW-1:0] w_wa;
    logic        n_we;
    logic [NW-1:0] n_wa, n_ra;
    logic signed [31:0] n_wd;

    function automatic logic [NW-1:0] slot(input logic [LW-1:0] l, input logic [JW-1:0] j);
        return NW'(l[LIW-1:0]) * NW'(MAX_LAYER_WIDTH) + NW'(j[CW-1:0]);
    endfunction

    always_ff @(posedge clk)
    begin
        if (w_we)
            wmem[w_wa] <= value;
        wrd <= (wp_reg < PW'(WEIGHT_DEPTH)) ? wmem[wp_reg[WW-1:0]] : 16'sd0;
        if (n_we)
            nmem[n_wa] <= n_wd;
        nrd <= nmem[n_ra];
    end

    mlp_sigmoid u_sig (
        .clk        (clk),
        .sum        (nrd),
        .final_node (state_reg == S_FIN_WAIT),
        .act        (act)
    );

    // rounded product and saturating add
    logic signed [47:0] pr;
    logic signed [35:0] q;
    logic signed [36:0] r;
    logic signed [31:0] acc_sat;
    always_comb
    begin
        pr = prod_reg + 48'sd2048;
        q = 36'(pr >>> 12);
        r = 37'(nrd) + 37'(q);
        if (r > 37'sd2147483647)
            acc_sat = 32'h7fffffff;
        else if (r < -37'sd2147483648)
            acc_sat = 32'h80000000;
        else
            acc_sat = r[31:0];
    end

    logic accept;
    assign accept = start && !busy;
    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        w_we = accept && (req_type == REQ_WEIGHT) && (32'(index) < WEIGHT_DEPTH);
        w_wa = WW'(index);
        n_we = 1'b0;
        n_wa = '0;
        n_wd = 32'(value);
        n_ra = '0;
        case (state_reg)
            S_CLEAR:
            begin
                n_we = 1'b1;
                n_wa = clr_reg[NW-1:0];
                n_wd = '0;
            end
            S_IDLE:
            begin
                n_we = accept && (req_type == REQ_INPUT)
                       && (index < 14'(clamp_size(lsize_reg[0])));
                n_wa = NW'(index[CW-1:0]);
            end
            S_ACT_RD:   n_ra = slot(lp_reg, s_reg);
            S_ACT_WR:
            begin
                n_we = 1'b1;
                n_wa = slot(lp_reg, s_reg);
                n_wd = 32'(act);
            end
            S_MAC_RD:   n_ra = slot(lp_reg, s_reg);
            S_MAC_MUL:  n_ra = slot(lp_reg + LW'(1), d_reg);
            S_MAC_ACC:
            begin
                n_we = 1'b1;
                n_wa = slot(lp_reg + LW'(1), d_reg);
                n_wd = acc_sat;
            end
            S_FIN_RD:   n_ra = slot(layers - LW'(1), size_of(layers - LW'(1)) - JW'(1));
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            lp_reg    <= '0;
            s_reg     <= '0;
            d_reg     <= '0;
            ns_reg    <= '0;
            nd_reg    <= '0;
            wp_reg    <= '0;
            woff_reg  <= '0;
            done      <= 1'b0;
            score     <= '0;
        end
        else
        begin
            done <= (state_reg == S_FIN_OUT);
            case (state_reg)
                S_CLEAR:
                begin
                    if (clr_reg == (NW+1)'(SLOTS - 1))
                    begin
                        clr_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                        clr_reg <= clr_reg + (NW+1)'(1);
                end
                S_IDLE:
                begin
                    if (accept && req_type == REQ_INPUT && last)
                    begin
                        lp_reg    <= '0;
                        woff_reg  <= '0;
                        state_reg <= S_LAYER;
                    end
                end
                S_LAYER:
                begin
                    if (lp_reg + LW'(1) >= layers)
                        state_reg <= S_FIN_RD;
                    else
                    begin
                        ns_reg <= size_of(lp_reg);
                        nd_reg <= size_of(lp_reg + LW'(1));
                        s_reg  <= '0;
                        d_reg  <= '0;
                        wp_reg <= woff_reg;
                        state_reg <= (lp_reg != '0) ? S_ACT_RD : S_MAC_RD;
                    end
                end
                S_ACT_RD:   state_reg <= S_ACT_WAIT;
                S_ACT_WAIT: state_reg <= S_ACT_WR;
                S_ACT_WR:
                begin
                    if (s_reg + JW'(1) == ns_reg)
                    begin
                        s_reg <= '0;
                        state_reg <= S_MAC_RD;
                    end
                    else
                    begin
                        s_reg <= s_reg + JW'(1);
                        state_reg <= S_ACT_RD;
                    end
                end
                S_MAC_RD:   state_reg <= S_MAC_RD2;
                S_MAC_RD2:
                begin
                    src_reg   <= nrd;
                    state_reg <= S_MAC_MUL;
                end
                S_MAC_MUL:
                begin
                    prod_reg  <= 48'(src_reg) * 48'(wrd);
                    state_reg <= S_MAC_ACC;
                end
                S_MAC_ACC:
                begin
                    wp_reg <= wp_reg + PW'(1);
                    if (d_reg + JW'(1) == nd_reg)
                    begin
                        d_reg <= '0;
                        if (s_reg + JW'(1) == ns_reg)
                        begin
                            woff_reg  <= wp_reg + PW'(1);
                            lp_reg    <= lp_reg + LW'(1);
                            state_reg <= S_LAYER;
                        end
                        else
                        begin
                            s_reg <= s_reg + JW'(1);
                            state_reg <= S_MAC_RD;
                        end
                    end
                    else
                    begin
                        d_reg <= d_reg + JW'(1);
                        state_reg <= S_MAC_RD;
                    end
                end
                S_FIN_RD:   state_reg <= S_FIN_WAIT;
                S_FIN_WAIT: state_reg <= S_FIN_OUT;
                S_FIN_OUT:
                begin
                    score     <= act;
                    clr_reg   <= '0;
                    state_reg <= S_CLEAR;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done lasted more than one cycle");
    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> score <= 13'd4096) else $error("score out of range");
    a_busy_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("block idle while result shown");
`endif
endmodule
`default_nettype wire

@@ dv/mlp_ff_checker.sv @@
// Scoreboard for mlp_feedforward_sigmoid: tracks APB writes and accepted items, predicts
// each score with its own fixed-point network model, and compares it with the done strobe.
// Depends on mlp_pkg for the register indexes and request codes.
module mlp_ff_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               start,
    input  logic               busy,
    input  logic               req_type,
    input  logic [13:0]        index,
    input  logic signed [15:0] value,
    input  logic               last,
    input  logic               done,
    input  logic [12:0]        score,
    output int                 errors,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import mlp_pkg::*;

    localparam int LAYERS_MAX = 4;
    localparam int WIDTH_MAX  = 64;
    localparam int WSTORE     = 16384;
    localparam int ACT_DEPTH  = 1024;

    logic [12:0]     act_rom [ACT_DEPTH];
    logic [2:0]      layer_cnt;
    logic [6:0]      layer_width [LAYERS_MAX];
    shortint         weights [WSTORE];
    int              nodes [LAYERS_MAX][WIDTH_MAX];
    logic [12:0]     score_q [$];
    int              result_no;

    initial
    begin
        longint unsigned e;
        longint unsigned q;
        e = 64'd1 << 32;
        for (int i = 0; i < ACT_DEPTH; i++)
        begin
            q = (64'd1 << 32) + e;
            act_rom[i] = 13'(((64'd1 << 44) + q / 2) / q);
            e = (e * 64'd4228380000 + (64'd1 << 31)) >> 32;
        end
        foreach (weights[i])
            weights[i] = 0;
        errors = 0;
        result_no = 0;
    end

    assign outstanding = score_q.size();

    function automatic int clamp_width(logic [6:0] raw);
        if (raw == 0)
            return 1;
        if (raw > WIDTH_MAX)
            return WIDTH_MAX;
        return int'(raw);
    endfunction

    function automatic int activate(int s, int sh);
        longint a;
        longint i;
        a = (s < 0) ? -longint'(s) : longint'(s);
        i = (a + (longint'(1) << (sh - 1))) >>> sh;
        if (i > ACT_DEPTH - 1)
            i = ACT_DEPTH - 1;
        return (s < 0) ? 4096 - int'(act_rom[i]) : int'(act_rom[i]);
    endfunction

    function automatic int mac(int acc, int node, shortint w);
        longint p;
        longint r;
        p = longint'(node) * longint'(w) + 2048;
        r = longint'(acc) + (p >>> 12);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return int'(r);
    endfunction

    // Run the whole network, then clear the node store as the block does.
    function automatic logic [12:0] net_score();
        int n [LAYERS_MAX];
        int nl;
        int woff;
        int wi;
        int res;
        nl = (layer_cnt < 2) ? 2 : ((layer_cnt > LAYERS_MAX) ? LAYERS_MAX : int'(layer_cnt));
        for (int k = 0; k < LAYERS_MAX; k++)
            n[k] = clamp_width(layer_width[k]);
        woff = 0;
        for (int l = 0; l + 1 < nl; l++)
        begin
            if (l >= 1)
                for (int j = 0; j < n[l]; j++)
                    nodes[l][j] = activate(nodes[l][j], 6);
            for (int s = 0; s < n[l]; s++)
                for (int d = 0; d < n[l + 1]; d++)
                begin
                    wi = woff + s * n[l + 1] + d;
                    nodes[l + 1][d] = mac(nodes[l + 1][d], nodes[l][s],
                                          (wi < WSTORE) ? weights[wi] : shortint'(0));
                end
            woff += n[l] * n[l + 1];
        end
        res = activate(nodes[nl - 1][n[nl - 1] - 1], 9);
        foreach (nodes[a, b])
            nodes[a][b] = 0;
        return res[12:0];
    endfunction

    task automatic flag_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int idx;
        if (!rst_n)
        begin
            layer_cnt = 3;
            layer_width[0] = 64;
            layer_width[1] = 32;
            layer_width[2] = 1;
            layer_width[3] = 1;
            foreach (nodes[a, b])
                nodes[a][b] = 0;
            score_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (score_q.size() == 0)
                    flag_mismatch($sformatf("score %0d with no item pending", score));
                else
                begin
                    if (score !== score_q[0])
                        flag_mismatch($sformatf("result %0d score %0d, want %0d",
                                                result_no, score, score_q[0]));
                    void'(score_q.pop_front());
                end
                result_no++;
            end
            if (psel && penable && pwrite && pready)
            begin
                idx = int'(paddr >> 2);
                if (idx == CFG_NUM_LAYERS)
                    layer_cnt = pwdata[2:0];
                else if (idx >= CFG_LAYER0 && idx <= CFG_LAYER3)
                    layer_width[idx - CFG_LAYER0] = pwdata[6:0];
            end
            if (start && !busy)
            begin
                if (req_type == REQ_WEIGHT)
                    weights[index] = shortint'(value);
                else
                begin
                    if (int'(index) < clamp_width(layer_width[0]))
                        nodes[0][index] = int'(value);
                    if (last)
                        score_q.insert(score_q.size(), net_score());
                end
            end
        end
    end
endmodule

@@ dv/tb.sv @@
// Top of the mlp_feedforward_sigmoid testbench: clock, reset, APB setup and item stimulus.
// Depends on mlp_pkg, the block and mlp_ff_checker, which does all prediction and checking.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mlp_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic               req_type;
    logic [13:0]        index;
    logic signed [15:0] value;
    logic               last;
    logic               done;
    logic [12:0]        score;
    int                 errors;
    int                 outstanding;

    bit                 weight_seen [16384];
    bit                 no_gaps;
    logic [6:0]         width_raw [4];
    logic [2:0]         layers_raw;

    mlp_feedforward_sigmoid dut (.*);

    mlp_ff_checker chk (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #60_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    function automatic int clamp_w(logic [6:0] raw);
        return (raw == 0) ? 1 : ((raw > 64) ? 64 : int'(raw));
    endfunction

    // Number of weights the current setup reads during one evaluation.
    function automatic int weights_used();
        int nl;
        int total;
        nl = (layers_raw < 2) ? 2 : ((layers_raw > 4) ? 4 : int'(layers_raw));
        total = 0;
        for (int l = 0; l + 1 < nl; l++)
            total += clamp_w(width_raw[l]) * clamp_w(width_raw[l + 1]);
        return total;
    endfunction

    // Call at a falling edge; returns at the falling edge after the item is taken.
    task automatic issue(logic rt, logic [13:0] idx, logic [15:0] val, logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_type = rt;
        index = idx;
        value = val;
        last = lst;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        if (rt == REQ_WEIGHT)
            weight_seen[idx] = 1'b1;
    endtask

    task automatic drain();
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        while (busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_write(logic [4:0] addr, logic [31:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic configure(logic [2:0] nl, logic [6:0] w0, logic [6:0] w1,
                             logic [6:0] w2, logic [6:0] w3);
        drain();
        layers_raw = nl;
        width_raw[0] = w0;
        width_raw[1] = w1;
        width_raw[2] = w2;
        width_raw[3] = w3;
        apb_write(5'(CFG_NUM_LAYERS * 4), 32'(nl) | 32'hFFFF_FFF8 & $urandom);
        for (int i = 0; i < 4; i++)
            apb_write(5'((CFG_LAYER0 + i) * 4), 32'(width_raw[i]));
    endtask

    // Write every weight the next evaluations will read that is still unwritten.
    task automatic fill_weights(bit extreme);
        int total;
        logic [15:0] v;
        total = weights_used();
        for (int i = 0; i < total; i++)
            if (!weight_seen[i])
            begin
                if (extreme)
                    v = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                else
                    v = 16'($urandom);
                issue(REQ_WEIGHT, 14'(i), v, 1'b0);
            end
    endtask

    task automatic random_phase(int count);
        int r;
        int w0;
        int total;
        w0 = clamp_w(width_raw[0]);
        total = weights_used();
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            if (r < 25)
                issue(REQ_WEIGHT, 14'($urandom_range(total - 1)), 16'($urandom), 1'b0);
            else if (r < 30)
                issue(REQ_WEIGHT, 14'($urandom), 16'($urandom), 1'($urandom));
            else if (r < 85)
                issue(REQ_INPUT, 14'($urandom_range(w0 - 1)), 16'($urandom),
                      $urandom_range(5) == 0);
            else
                issue(REQ_INPUT, 14'($urandom_range(16383, w0)), 16'($urandom),
                      $urandom_range(7) == 0);
        end
        issue(REQ_INPUT, 14'($urandom_range(w0 - 1)), 16'($urandom), 1'b1);
    endtask

    initial
    begin
        logic [6:0] sz [4];
        logic [2:0] nl;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        req_type = REQ_WEIGHT;
        index = '0;
        value = '0;
        last = 1'b0;
        no_gaps = 1'b0;
        layers_raw = 3;
        width_raw[0] = 64;
        width_raw[1] = 32;
        width_raw[2] = 1;
        width_raw[3] = 1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Reset setup with a narrow second layer: 64-2-1.
        drain();
        width_raw[1] = 7'd2;
        apb_write(5'(CFG_LAYER1 * 4), 32'd2);
        fill_weights(1'b0);
        issue(REQ_INPUT, 14'd0, 16'h7FFF, 1'b0);
        issue(REQ_INPUT, 14'd63, 16'h8000, 1'b0);
        issue(REQ_INPUT, 14'd64, 16'h1234, 1'b0);
        issue(REQ_INPUT, 14'd16383, 16'hFFFF, 1'b0);
        issue(REQ_WEIGHT, 14'd5, 16'h0800, 1'b1);
        issue(REQ_INPUT, 14'd5, 16'h0000, 1'b1);
        // No inputs loaded since the last evaluation.
        issue(REQ_INPUT, 14'd16383, 16'h0001, 1'b1);
        issue(REQ_INPUT, 14'd1, 16'h2000, 1'b1);

        // Smallest network; a write beyond the register list is dropped.
        configure(3'd2, 7'd1, 7'd1, 7'd1, 7'd1);
        apb_write(5'd20, 32'd3);
        fill_weights(1'b1);
        issue(REQ_INPUT, 14'd0, 16'h7FFF, 1'b1);
        issue(REQ_INPUT, 14'd0, 16'h8000, 1'b1);
        issue(REQ_INPUT, 14'd1, 16'h7FFF, 1'b1);

        // Four layers with a full-width input layer, full-scale weights.
        configure(3'd4, 7'd64, 7'd2, 7'd3, 7'd2);
        no_gaps = 1'b1;
        fill_weights(1'b1);
        no_gaps = 1'b0;
        for (int i = 0; i < 64; i += 9)
            issue(REQ_INPUT, 14'(i), (i % 2) ? 16'h8000 : 16'h7FFF, 1'b0);
        issue(REQ_INPUT, 14'd63, 16'h7FFF, 1'b1);
        issue(REQ_INPUT, 14'd10, 16'h8000, 1'b1);

        // Layer count and sizes saturate.
        configure(3'd0, 7'd0, 7'd127, 7'd0, 7'd127);
        fill_weights(1'b0);
        issue(REQ_INPUT, 14'd0, 16'h4000, 1'b1);
        configure(3'd7, 7'd3, 7'd0, 7'd5, 7'd2);
        fill_weights(1'b0);
        issue(REQ_INPUT, 14'd2, 16'hC000, 1'b1);

        for (int ph = 0; ph < 8; ph++)
        begin
            for (int i = 0; i < 4; i++)
                sz[i] = ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(8, 1));
            nl = ($urandom_range(5) == 0) ? 3'($urandom) : 3'($urandom_range(4, 2));
            configure(nl, sz[0], sz[1], sz[2], sz[3]);
            fill_weights($urandom_range(3) == 0);
            no_gaps = (ph % 3 == 1);
            random_phase(90);
            no_gaps = 1'b0;
        end

        drain();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

@@ mlp_feedforward_sigmoid.f @@
hw/rtl/mlp_pkg.sv
hw/rtl/mlp_sigmoid.sv
hw/rtl/mlp_feedforward_sigmoid.sv
dv/mlp_ff_checker.sv
dv/tb.sv
